>>> rtl/gsp_pkg.sv
`timescale 1ns / 1ps

package gsp_pkg;

	// Sequencer phases.
	localparam logic [3:0] P_IDLE   = 4'd0;
	localparam logic [3:0] P_SETTLE = 4'd1;
	localparam logic [3:0] P_LOW    = 4'd2;
	localparam logic [3:0] P_HIGH   = 4'd3;
	localparam logic [3:0] P_GAP    = 4'd4;
	localparam logic [3:0] P_END    = 4'd5;

	// Pin level bits: attention, clock, command.
	localparam logic [2:0] PIN_ATT  = 3'b100;
	localparam logic [2:0] PIN_CLK  = 3'b010;
	localparam logic [2:0] PIN_CMD  = 3'b001;
	localparam logic [2:0] PINS_IDLE = 3'b111;

	// Command and reply bytes.
	localparam logic [7:0] CMD_START = 8'h01;
	localparam logic [7:0] CMD_POLL  = 8'h42;
	localparam logic [7:0] CMD_IDLE  = 8'h00;
	localparam logic [7:0] REPLY_ACK = 8'h5A;

	// Outcome codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BAD_ID = 2'd1;
	localparam logic [1:0] ST_NO_ACK = 2'd2;

	localparam logic [7:0] HALF_RESET = 8'd10;

	// One result word per tick.
	typedef struct packed {
		logic        attention_level;
		logic        clock_level;
		logic        command_level;
		logic        word_valid;
		logic [15:0] button_word;
		logic [3:0]  word_index;
		logic        done_res;
		logic [1:0]  status;
		logic [7:0]  id_reply;
		logic [3:0]  word_count;
		logic        busy_res;
	} gsp_res_t;

	// Command bit driven for the given byte position and bit.
	function automatic logic cmd_bit(logic in_data, logic [4:0] byte_cnt, logic [2:0] bit_cnt);
		logic [7:0] cmd;
		if (in_data)
			cmd = CMD_IDLE;
		else if (byte_cnt == 5'd0)
			cmd = CMD_START;
		else if (byte_cnt == 5'd1)
			cmd = CMD_POLL;
		else
			cmd = CMD_IDLE;
		return cmd[bit_cnt];
	endfunction

	// Accepted pad ID classes by high nibble.
	function automatic logic id_ok(logic [7:0] id);
		logic [3:0] n;
		n = id[7:4];
		return (n == 4'h1) || (n == 4'h2) || (n == 4'h4) || (n == 4'h5) || (n == 4'h7);
	endfunction

endpackage

>>> rtl/gamepad_serial_poll_unit.sv
`timescale 1ns / 1ps
// A tick word waits in the input register; its result word is loaded into the result
// register when that register is free or draining. Throughput: one tick word per cycle
// while the result register is not stalled; the sequencer state updates once per word.
// Reset: all lines idle high, sequencer idle, status and ID cleared, half period 10.
// The half period register is written through wr_en and wr_data.

module gamepad_serial_poll_unit import gsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        start_req,
	input  logic        data_level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        attention_level,
	output logic        clock_level,
	output logic        command_level,
	output logic        word_valid,
	output logic [15:0] button_word,
	output logic [3:0]  word_index,
	output logic        done_res,
	output logic [1:0]  status,
	output logic [7:0]  id_reply,
	output logic [3:0]  word_count,
	output logic        busy_res,
	input  logic        wr_en,
	input  logic [7:0]  wr_data
);

	logic       in_valid_s1;
	logic       start_s1;
	logic       data_s1;
	logic       out_valid_q;
	gsp_res_t   res_q;
	gsp_res_t   res;
	logic [7:0] half_q;
	logic       advance;

	// A tick moves into the result register when that register is free or draining.
	assign advance  = in_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = in_valid_s1 && !advance;

	// Half period register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			half_q <= HALF_RESET;
		else if (wr_en)
			half_q <= wr_data;
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_valid_s1 <= 1'b0;
		else if (!in_stall)
			in_valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			start_s1 <= start_req;
			data_s1  <= data_level;
		end
	end

	gsp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.start_req  (start_s1),
		.data_level (data_s1),
		.half_ticks (half_q),
		.res        (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

	assign out_valid       = out_valid_q;
	assign attention_level = res_q.attention_level;
	assign clock_level     = res_q.clock_level;
	assign command_level   = res_q.command_level;
	assign word_valid      = res_q.word_valid;
	assign button_word     = res_q.button_word;
	assign word_index      = res_q.word_index;
	assign done_res        = res_q.done_res;
	assign status          = res_q.status;
	assign id_reply        = res_q.id_reply;
	assign word_count      = res_q.word_count;
	assign busy_res        = res_q.busy_res;

endmodule

>>> rtl/gsp_ctrl.sv
`timescale 1ns / 1ps

module gsp_ctrl import gsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic       start_req,
	input  logic       data_level,
	input  logic [7:0] half_ticks,
	output gsp_res_t   res
);

	logic [3:0] phase_q;
	logic [8:0] timer_q;
	logic [2:0] bit_q;
	logic [4:0] byte_q;
	logic [7:0] shift_q;
	logic [7:0] high_q;
	logic [7:0] id_q;
	logic [1:0] status_q;
	logic       in_data_q;
	logic [2:0] pins_q;

	logic [3:0] n_phase;
	logic [8:0] n_timer;
	logic [2:0] n_bit;
	logic [4:0] n_byte;
	logic [7:0] n_shift;
	logic [7:0] n_high;
	logic [7:0] n_id;
	logic [1:0] n_status;
	logic       n_in_data;
	logic [2:0] n_pins;
	logic       wv;
	logic [15:0] word;
	logic [3:0] widx;
	logic       done_w;

	// One tick of the poll sequencer.
	always_comb begin
		logic [8:0] half;
		logic [8:0] half2;
		logic [7:0] rx_byte;
		logic [4:0] byte_inc;
		logic       go_bit;
		logic       go_end;
		logic [1:0] end_st;

		half     = (half_ticks == 8'd0) ? 9'd1 : {1'b0, half_ticks};
		half2    = {half[7:0], 1'b0};
		rx_byte  = shift_q;
		byte_inc = byte_q + 5'd1;
		go_bit   = 1'b0;
		go_end   = 1'b0;
		end_st   = ST_OK;

		n_phase   = phase_q;
		n_timer   = timer_q;
		n_bit     = bit_q;
		n_byte    = byte_q;
		n_shift   = shift_q;
		n_high    = high_q;
		n_id      = id_q;
		n_status  = status_q;
		n_in_data = in_data_q;
		n_pins    = pins_q;
		wv        = 1'b0;
		word      = 16'd0;
		widx      = 4'd0;
		done_w    = 1'b0;

		if (phase_q == P_IDLE) begin
			if (start_req) begin
				n_bit     = 3'd0;
				n_byte    = 5'd0;
				n_shift   = 8'd0;
				n_high    = 8'd0;
				n_id      = 8'd0;
				n_status  = ST_OK;
				n_in_data = 1'b0;
				n_pins    = PIN_CLK | PIN_CMD;
				n_phase   = P_SETTLE;
				n_timer   = half2;
			end
		end else begin
			n_timer = timer_q - 9'd1;
			if (n_timer == 9'd0) begin
				unique case (phase_q)
					P_SETTLE: begin
						n_bit  = 3'd0;
						go_bit = 1'b1;
					end
					P_LOW: begin
						n_pins  = pins_q | PIN_CLK;
						n_phase = P_HIGH;
						n_timer = half;
					end
					P_HIGH: begin
						if (data_level)
							n_shift[bit_q] = 1'b1;
						if (bit_q != 3'd7) begin
							n_bit  = bit_q + 3'd1;
							go_bit = 1'b1;
						end else begin
							n_phase = P_GAP;
							n_timer = half2;
						end
					end
					P_GAP: begin
						n_shift = 8'd0;
						n_bit   = 3'd0;
						if (!in_data_q) begin
							if (byte_q == 5'd0) begin
								n_byte = 5'd1;
								go_bit = 1'b1;
							end else if (byte_q == 5'd1) begin
								n_id = rx_byte;
								if (id_ok(rx_byte)) begin
									n_byte = 5'd2;
									go_bit = 1'b1;
								end else begin
									go_end = 1'b1;
									end_st = ST_BAD_ID;
								end
							end else if (rx_byte != REPLY_ACK) begin
								go_end = 1'b1;
								end_st = ST_NO_ACK;
							end else if (id_q[3:0] == 4'd0) begin
								go_end = 1'b1;
								end_st = ST_OK;
							end else begin
								n_in_data = 1'b1;
								n_byte    = 5'd0;
								go_bit    = 1'b1;
							end
						end else if (!byte_q[0]) begin
							n_high = rx_byte;
							n_byte = byte_inc;
							go_bit = 1'b1;
						end else begin
							wv     = 1'b1;
							word   = ~{high_q, rx_byte};
							widx   = byte_q[4:1];
							n_byte = byte_inc;
							if (byte_inc[4:1] >= id_q[3:0]) begin
								go_end = 1'b1;
								end_st = ST_OK;
							end else begin
								go_bit = 1'b1;
							end
						end
					end
					P_END: begin
						n_pins  = PINS_IDLE;
						n_phase = P_IDLE;
						done_w  = 1'b1;
					end
					default: begin
						n_pins  = PINS_IDLE;
						n_phase = P_IDLE;
					end
				endcase

				// Start of a bit: drive command, pull clock low.
				if (go_bit) begin
					n_pins  = (pins_q & PIN_ATT) |
						(cmd_bit(n_in_data, n_byte, n_bit) ? PIN_CMD : 3'b000);
					n_phase = P_LOW;
					n_timer = half;
				end

				// End of the poll: release attention and wait out the gap.
				if (go_end) begin
					n_status = end_st;
					n_pins   = n_pins | PIN_ATT;
					n_phase  = P_END;
					n_timer  = half2;
				end
			end
		end
	end

	// Sequencer state advances once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= P_IDLE;
			timer_q   <= 9'd0;
			bit_q     <= 3'd0;
			byte_q    <= 5'd0;
			shift_q   <= 8'd0;
			high_q    <= 8'd0;
			id_q      <= 8'd0;
			status_q  <= ST_OK;
			in_data_q <= 1'b0;
			pins_q    <= PINS_IDLE;
		end else if (fire) begin
			phase_q   <= n_phase;
			timer_q   <= n_timer;
			bit_q     <= n_bit;
			byte_q    <= n_byte;
			shift_q   <= n_shift;
			high_q    <= n_high;
			id_q      <= n_id;
			status_q  <= n_status;
			in_data_q <= n_in_data;
			pins_q    <= n_pins;
		end
	end

	// Result word for this tick, levels after the update.
	always_comb begin
		res.attention_level = n_pins[2];
		res.clock_level     = n_pins[1];
		res.command_level   = n_pins[0];
		res.word_valid      = wv;
		res.button_word     = word;
		res.word_index      = widx;
		res.done_res        = done_w;
		res.status          = n_status;
		res.id_reply        = n_id;
		res.word_count      = n_id[3:0];
		res.busy_res        = (n_phase != P_IDLE);
	end

	// A button word only completes at the end of a byte gap.
	a_word_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		res.word_valid |-> (phase_q == P_GAP && in_data_q))
		else $error("button word outside a data byte gap");

	// The timer is loaded nonzero whenever a tick leaves the sequencer busy.
	a_timer_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && n_phase != P_IDLE) |=> (timer_q != 9'd0))
		else $error("busy phase entered with a zero timer");

	// All lines idle high while the sequencer is idle.
	a_idle_pins: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == P_IDLE) |-> (pins_q == PINS_IDLE))
		else $error("lines not idle high in idle phase");

	// Attention stays high during the closing gap.
	a_end_att: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == P_END) |-> pins_q[2])
		else $error("attention low in closing gap");

endmodule

>>> sim/gamepad_serial_poll_unit_tb.sv
`timescale 1ns / 1ps

module gamepad_serial_poll_unit_tb;
	import gsp_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_TICKS_PER_PATTERN = 40;

	typedef enum logic [1:0] {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;

	// One row of the directed table: a run of idle ticks or one pad transaction.
	typedef struct packed {
		logic        is_poll;
		logic        set_half;
		logic [7:0]  half;
		logic [7:0]  id;
		logic [7:0]  ack;
		fill_t       fill;
		logic [6:0]  start_pct;
		logic [9:0]  noise;
		logic        typed;
		logic [1:0]  want_status;
	} poll_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        start_req = 1'b0;
	logic        data_level = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        attention_level;
	logic        clock_level;
	logic        command_level;
	logic        word_valid;
	logic [15:0] button_word;
	logic [3:0]  word_index;
	logic        done_res;
	logic [1:0]  status;
	logic [7:0]  id_reply;
	logic [3:0]  word_count;
	logic        busy_res;
	logic        wr_en = 1'b0;
	logic [7:0]  wr_data = 8'd0;

	gamepad_serial_poll_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.start_req       (start_req),
		.data_level      (data_level),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.attention_level (attention_level),
		.clock_level     (clock_level),
		.command_level   (command_level),
		.word_valid      (word_valid),
		.button_word     (button_word),
		.word_index      (word_index),
		.done_res        (done_res),
		.status          (status),
		.id_reply        (id_reply),
		.word_count      (word_count),
		.busy_res        (busy_res),
		.wr_en           (wr_en),
		.wr_data         (wr_data)
	);

	// Shadow copy of the poll sequencer.
	logic [7:0] half_ticks;
	logic [3:0] seq_phase;
	logic [8:0] tick_left;
	logic [2:0] bit_pos;
	logic [4:0] byte_pos;
	logic [7:0] shift_in;
	logic [7:0] word_hi;
	logic [7:0] pad_id;
	logic [1:0] outcome;
	logic       in_words;
	logic [2:0] pins;

	// Reply bytes the emulated pad sends during the current transaction.
	logic [7:0] plan_first;
	logic [7:0] plan_id;
	logic [7:0] plan_ack;
	logic [7:0] plan_data [32];
	int         plan_noise;

	gsp_res_t   line_words_due [$];
	gsp_res_t   last_seen;
	int         mismatches = 0;
	int         tick_count = 0;
	int         active_ticks = 0;
	int         words_built = 0;
	int         half_writes = 0;
	int         outcome_seen [3] = '{0, 0, 0};
	int         send_idle_pct = 0;
	int         stall_pct = 0;
	int         quiet = 0;
	poll_row_t  plan_table [7];

	// Clock, 12 ns period.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [8:0] half_len();
		return (half_ticks == 8'd0) ? 9'd1 : {1'b0, half_ticks};
	endfunction

	// Put the next command bit on the line and open the clock-low half period.
	function automatic void start_bit();
		logic [7:0] cmd;
		if (in_words || byte_pos > 5'd1)
			cmd = CMD_IDLE;
		else if (byte_pos == 5'd0)
			cmd = CMD_START;
		else
			cmd = CMD_POLL;
		pins = (pins & PIN_ATT) | (cmd[bit_pos] ? PIN_CMD : 3'b000);
		seq_phase = P_LOW;
		tick_left = half_len();
	endfunction

	function automatic void end_poll(input logic [1:0] st);
		outcome = st;
		pins = pins | PIN_ATT;
		seq_phase = P_END;
		tick_left = half_len() << 1;
	endfunction

	// Advance the shadow sequencer by one tick and build the line word it yields.
	function automatic gsp_res_t poll_step(input logic start, input logic data);
		gsp_res_t r;
		logic [7:0] got;
		r = '0;
		if (seq_phase == P_IDLE) begin
			if (start) begin
				bit_pos = 3'd0;
				byte_pos = 5'd0;
				shift_in = 8'd0;
				word_hi = 8'd0;
				pad_id = 8'd0;
				outcome = ST_OK;
				in_words = 1'b0;
				pins = PIN_CLK | PIN_CMD;
				seq_phase = P_SETTLE;
				tick_left = half_len() << 1;
			end
		end else begin
			tick_left = tick_left - 9'd1;
			if (tick_left == 9'd0) begin
				case (seq_phase)
					P_SETTLE: begin
						bit_pos = 3'd0;
						start_bit();
					end
					P_LOW: begin
						pins = pins | PIN_CLK;
						seq_phase = P_HIGH;
						tick_left = half_len();
					end
					P_HIGH: begin
						if (data)
							shift_in[bit_pos] = 1'b1;
						if (bit_pos < 3'd7) begin
							bit_pos = bit_pos + 3'd1;
							start_bit();
						end else begin
							seq_phase = P_GAP;
							tick_left = half_len() << 1;
						end
					end
					P_GAP: begin
						got = shift_in;
						shift_in = 8'd0;
						bit_pos = 3'd0;
						if (!in_words) begin
							if (byte_pos == 5'd0) begin
								byte_pos = 5'd1;
								start_bit();
							end else if (byte_pos == 5'd1) begin
								pad_id = got;
								case (got[7:4]) inside
									4'h1, 4'h2, 4'h4, 4'h5, 4'h7: begin
										byte_pos = 5'd2;
										start_bit();
									end
									default: end_poll(ST_BAD_ID);
								endcase
							end else if (got != REPLY_ACK) begin
								end_poll(ST_NO_ACK);
							end else if (pad_id[3:0] == 4'd0) begin
								end_poll(ST_OK);
							end else begin
								in_words = 1'b1;
								byte_pos = 5'd0;
								start_bit();
							end
						end else if (!byte_pos[0]) begin
							word_hi = got;
							byte_pos = byte_pos + 5'd1;
							start_bit();
						end else begin
							r.word_valid = 1'b1;
							r.button_word = ~{word_hi, got};
							r.word_index = byte_pos[4:1];
							words_built++;
							byte_pos = byte_pos + 5'd1;
							if (byte_pos[4:1] >= pad_id[3:0])
								end_poll(ST_OK);
							else
								start_bit();
						end
					end
					P_END: begin
						pins = PINS_IDLE;
						seq_phase = P_IDLE;
						r.done_res = 1'b1;
						outcome_seen[outcome]++;
					end
					default: begin
						pins = PINS_IDLE;
						seq_phase = P_IDLE;
					end
				endcase
			end
		end
		r.attention_level = pins[2];
		r.clock_level = pins[1];
		r.command_level = pins[0];
		r.status = outcome;
		r.id_reply = pad_id;
		r.word_count = pad_id[3:0];
		r.busy_res = (seq_phase != P_IDLE);
		return r;
	endfunction

	// Data line level the emulated pad drives for the bit now on the wire.
	function automatic logic pad_bit();
		logic [7:0] b;
		if (seq_phase != P_LOW && seq_phase != P_HIGH)
			return 1'($urandom_range(1));
		if (in_words)
			b = plan_data[byte_pos];
		else if (byte_pos == 5'd0)
			b = plan_first;
		else if (byte_pos == 5'd1)
			b = plan_id;
		else
			b = plan_ack;
		if ($urandom_range(999) < plan_noise)
			return ~b[bit_pos];
		return b[bit_pos];
	endfunction

	function automatic string show(input gsp_res_t w);
		return $sformatf({"att=%b clk=%b cmd=%b wv=%b word=%h idx=%0d done=%b",
			" st=%0d id=%h cnt=%0d busy=%b"},
			w.attention_level, w.clock_level, w.command_level, w.word_valid, w.button_word,
			w.word_index, w.done_res, w.status, w.id_reply, w.word_count, w.busy_res);
	endfunction

	task automatic report_mismatch(input string what, input gsp_res_t want, input gsp_res_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%t: %s mismatch", $realtime, what);
			$display("  expected %s", show(want));
			$display("  actual   %s", show(got));
		end
	endtask

	// Offer one tick word, wait for it to be taken, then predict its line word.
	task automatic send_tick(input logic start, input logic data);
		gsp_res_t want;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		start_req = start;
		data_level = data;
		do
			@(posedge clk);
		while (in_stall);
		tick_count++;
		if (seq_phase != P_IDLE || start)
			active_ticks++;
		want = poll_step(start, data);
		line_words_due.push_back(want);
	endtask

	// Stop offering ticks, let every predicted word come out, then let the pipeline settle.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (line_words_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_half_period(input logic [7:0] v);
		drain();
		@(negedge clk);
		wr_en = 1'b1;
		wr_data = v;
		@(negedge clk);
		wr_en = 1'b0;
		half_ticks = v;
		half_writes++;
	endtask

	// One full transaction against the emulated pad, with optional stray starts.
	task automatic run_poll(input poll_row_t r);
		int i;
		plan_first = 8'($urandom);
		plan_id = r.id;
		plan_ack = r.ack;
		plan_noise = r.noise;
		for (i = 0; i < 32; i++) begin
			case (r.fill)
				FILL_ZERO: plan_data[i] = 8'h00;
				FILL_ONES: plan_data[i] = 8'hFF;
				default:   plan_data[i] = 8'($urandom);
			endcase
		end
		send_tick(1'b1, pad_bit());
		while (seq_phase != P_IDLE)
			send_tick($urandom_range(99) < r.start_pct, pad_bit());
	endtask

	// Receiver back-pressure.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Compare each line word taken from the block with the oldest prediction.
	always @(posedge clk) begin : check_words
		gsp_res_t got;
		gsp_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {attention_level, clock_level, command_level, word_valid, button_word,
				word_index, done_res, status, id_reply, word_count, busy_res};
			last_seen <= got;
			if (line_words_due.size() == 0) begin
				report_mismatch("unexpected line word", got, got);
			end else begin
				want = line_words_due.pop_front();
				if (got !== want)
					report_mismatch("line word", want, got);
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet <= 0;
			end else if (quiet + 1 >= QUIET_LIMIT) begin
				$display("Watchdog: no word moved in %0d cycles, %0d still due",
					QUIET_LIMIT, line_words_due.size());
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	initial begin
		int mode;
		int i;
		int target;
		poll_row_t rnd;
		gsp_res_t typed_want;

		// Columns: poll, write half, half, ID, ack, fill, start %, noise, typed, status.
		plan_table[0] = '{1'b0, 1'b0, 8'd0, 8'h00, 8'h00, FILL_RAND, 7'd0,   10'd0,  1'b1, ST_OK};
		plan_table[1] = '{1'b1, 1'b1, 8'd1, 8'h10, 8'h5A, FILL_RAND, 7'd100, 10'd0,  1'b0, ST_OK};
		plan_table[2] = '{1'b1, 1'b1, 8'd0, 8'h51, 8'h5A, FILL_ZERO, 7'd0,   10'd0,  1'b1, ST_OK};
		plan_table[3] = '{1'b1, 1'b0, 8'd0, 8'h21, 8'h5A, FILL_ONES, 7'd0,   10'd0,  1'b1, ST_OK};
		plan_table[4] = '{1'b1, 1'b0, 8'd0, 8'h30, 8'h5A, FILL_RAND, 7'd0,   10'd0,  1'b1,
			ST_BAD_ID};
		plan_table[5] = '{1'b1, 1'b0, 8'd0, 8'h41, 8'hA5, FILL_RAND, 7'd0,   10'd0,  1'b1,
			ST_NO_ACK};
		plan_table[6] = '{1'b1, 1'b1, 8'd2, 8'h70, 8'h5A, FILL_RAND, 7'd30,  10'd20, 1'b0, ST_OK};

		// Shadow state after reset.
		half_ticks = HALF_RESET;
		seq_phase = P_IDLE;
		tick_left = 9'd0;
		bit_pos = 3'd0;
		byte_pos = 5'd0;
		shift_in = 8'd0;
		word_hi = 8'd0;
		pad_id = 8'd0;
		outcome = ST_OK;
		in_words = 1'b0;
		pins = PINS_IDLE;
		plan_noise = 0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table.
		for (i = 0; i < 7; i++) begin
			if (plan_table[i].set_half)
				set_half_period(plan_table[i].half);
			if (plan_table[i].is_poll)
				run_poll(plan_table[i]);
			else
				repeat (5) send_tick(1'b0, 1'($urandom_range(1)));
			if (plan_table[i].typed) begin
				drain();
				typed_want = last_seen;
				typed_want.status = plan_table[i].want_status;
				typed_want.id_reply = plan_table[i].id;
				typed_want.word_count = plan_table[i].id[3:0];
				typed_want.busy_res = 1'b0;
				if (last_seen !== typed_want)
					report_mismatch($sformatf("directed row %0d outcome", i), typed_want,
						last_seen);
			end
		end

		// Random transactions under each handshake pattern.
		for (mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 52; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 52; end
				default: begin send_idle_pct = 6; stall_pct = 6; end
			endcase
			set_half_period(8'd1);
			target = active_ticks + RANDOM_TICKS_PER_PATTERN;
			while (active_ticks < target) begin
				if ($urandom_range(3) == 0)
					set_half_period(($urandom_range(9) < 6) ? 8'd1 : 8'($urandom_range(2)));
				rnd = '0;
				rnd.is_poll = 1'b1;
				// Mostly well-formed pads with short reports; the rest get a random ID.
				if ($urandom_range(3) != 0) begin
					case ($urandom_range(4))
						0: rnd.id[7:4] = 4'h1;
						1: rnd.id[7:4] = 4'h2;
						2: rnd.id[7:4] = 4'h4;
						3: rnd.id[7:4] = 4'h5;
						default: rnd.id[7:4] = 4'h7;
					endcase
					if ($urandom_range(9) < 7)
						rnd.id[3:0] = 4'($urandom_range(2));
					else
						rnd.id[3:0] = 4'($urandom_range(3));
				end else begin
					rnd.id = 8'($urandom) & 8'hF3;
				end
				rnd.ack = ($urandom_range(99) < 85) ? REPLY_ACK : 8'($urandom);
				case ($urandom_range(7))
					0: rnd.fill = FILL_ZERO;
					1: rnd.fill = FILL_ONES;
					default: rnd.fill = FILL_RAND;
				endcase
				rnd.start_pct = 7'($urandom_range(50));
				rnd.noise = ($urandom_range(4) == 0) ? 10'd5 : 10'd0;
				run_poll(rnd);
				repeat ($urandom_range(3)) send_tick(1'b0, 1'($urandom_range(1)));
			end
		end

		drain();
		repeat (10) @(posedge clk);
		$display("Sent %0d tick words (%0d inside transactions) under four handshake patterns,",
			tick_count, active_ticks);
		$display("with %0d half-period writes: %0d ok, %0d bad ID, %0d missing ack, %0d words.",
			half_writes, outcome_seen[0], outcome_seen[1], outcome_seen[2], words_built);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
